/* hdl/ipn_pkg.sv */
// Shared types and constants for the inspiral phase-of-time unit.
// No dependencies.
`default_nettype none
package ipn_pkg;

    localparam int TIME_W  = 48;
    localparam int COEF_W  = 48;
    localparam int ETA_W   = 32;
    localparam int PHASE_W = 64;
    localparam int ROOT_W  = 32;
    localparam int RAD_W   = 64;
    localparam int ACC_W   = 90;
    localparam int DIV_W   = ETA_W + 4;

    typedef enum logic [2:0] {
        CFG_PN_ORDER    = 3'd0,
        CFG_COEF_CUBIC  = 3'd1,
        CFG_COEF_SQUARE = 3'd2,
        CFG_COEF_LINEAR = 3'd3,
        CFG_ETA_HALF    = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PN_NEWTON = 2'd0,
        PN_2PN    = 2'd1,
        PN_3PN    = 2'd2,
        PN_4PN    = 2'd3
    } t_pn_order;

    localparam logic [PHASE_W-1:0] PHASE_MAX = {1'b0, {(PHASE_W-1){1'b1}}};
    localparam logic [PHASE_W-1:0] PHASE_MIN = {1'b1, {(PHASE_W-1){1'b0}}};
    localparam logic [ETA_W-1:0]   ETA_RESET = 32'h2000_0000;

    typedef struct packed {
        logic s_neg;
        logic zero;
        logic bad;
    } t_div_side;

    function automatic logic [COEF_W-1:0] coef_mag(input logic [COEF_W-1:0] c);
        coef_mag = c[COEF_W-1] ? (~c + 1'b1) : c;
    endfunction

endpackage
`default_nettype wire

/* hdl/inspiral_pn_phase_of_time_unit.sv */
// Inspiral phase of time: eighth root, power series, divide, saturate.
// Takes one request per cycle while no result waits unaccepted at the output.
// Stages: input 1, three roots 96, products 6, sum 4, divide 90, output 1.
// Whole pipeline holds while a result waits; the input stage still fills if empty.
// Synchronous active-low reset clears valid bits and loads register defaults.
// Depends on ipn_pkg, ipn_isqrt, ipn_mul, ipn_div.
`default_nettype none
module inspiral_pn_phase_of_time_unit
    import ipn_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire [TIME_W-1:0]    i_time_to_merge,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [PHASE_W-1:0]  o_phase,
    output logic                o_bad_time,
    input  wire                 i_cfg_we,
    input  wire [2:0]           i_cfg_idx,
    input  wire [COEF_W-1:0]    i_cfg_data
);
    logic [1:0]        r_pn_order;
    logic [COEF_W-1:0] r_coef_c, r_coef_s, r_coef_l;
    logic [ETA_W-1:0]  r_eta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pn_order <= PN_4PN;
            r_coef_c   <= '0;
            r_coef_s   <= '0;
            r_coef_l   <= '0;
            r_eta      <= ETA_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PN_ORDER:    r_pn_order <= i_cfg_data[1:0];
                CFG_COEF_CUBIC:  r_coef_c   <= i_cfg_data;
                CFG_COEF_SQUARE: r_coef_s   <= i_cfg_data;
                CFG_COEF_LINEAR: r_coef_l   <= i_cfg_data;
                CFG_ETA_HALF:    r_eta      <= i_cfg_data[ETA_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_ov;
    assign en = !r_ov || i_out_ready;

    logic              r_v0;
    logic [TIME_W-1:0] r_t;
    assign o_in_ready = en || !r_v0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (o_in_ready) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_t <= i_time_to_merge;
        end
    end

    logic              v_r1, v_r2, v_th;
    logic [ROOT_W-1:0] r1, r2, th;
    logic              b_r1, b_r2, b_th;

    ipn_isqrt #(.W_SIDE(1)) u_sq1 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v0),
        .i_rad({r_t, 16'b0}), .i_side(r_t == '0),
        .o_valid(v_r1), .o_root(r1), .o_side(b_r1)
    );
    ipn_isqrt #(.W_SIDE(1)) u_sq2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_r1),
        .i_rad({r1, 32'b0}), .i_side(b_r1),
        .o_valid(v_r2), .o_root(r2), .o_side(b_r2)
    );
    ipn_isqrt #(.W_SIDE(1)) u_sq3 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_r2),
        .i_rad({r2, 32'b0}), .i_side(b_r2),
        .o_valid(v_th), .o_root(th), .o_side(b_th)
    );

    logic        v_m1, v_m2, v_m3;
    logic [63:0] p_m1;
    logic [32:0] s_m1;
    logic [67:0] p_m2;
    logic [68:0] s_m2;
    logic [75:0] p_m3;
    logic        b_m3;
    logic [87:0] p_c;
    logic [83:0] p_s;
    logic [79:0] p_l;

    ipn_mul #(.WA(32), .WB(32), .W_SIDE(33)) u_m1 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_th),
        .i_a(th), .i_b(th), .i_side({th, b_th}),
        .o_valid(v_m1), .o_prod(p_m1), .o_side(s_m1)
    );
    ipn_mul #(.WA(36), .WB(32), .W_SIDE(69)) u_m2 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_m1),
        .i_a(p_m1[63:28]), .i_b(s_m1[32:1]),
        .i_side({p_m1[63:28], s_m1}),
        .o_valid(v_m2), .o_prod(p_m2), .o_side(s_m2)
    );
    ipn_mul #(.WA(40), .WB(36), .W_SIDE(1)) u_m3 (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_m2),
        .i_a(p_m2[67:28]), .i_b(s_m2[68:33]), .i_side(s_m2[0]),
        .o_valid(v_m3), .o_prod(p_m3), .o_side(b_m3)
    );
    ipn_mul #(.WA(48), .WB(40), .W_SIDE(1)) u_mc (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_m2),
        .i_a(coef_mag(r_coef_c)), .i_b(p_m2[67:28]), .i_side(1'b0),
        .o_valid(), .o_prod(p_c), .o_side()
    );
    ipn_mul #(.WA(48), .WB(36), .W_SIDE(1)) u_ms (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_m2),
        .i_a(coef_mag(r_coef_s)), .i_b(s_m2[68:33]), .i_side(1'b0),
        .o_valid(), .o_prod(p_s), .o_side()
    );
    ipn_mul #(.WA(48), .WB(32), .W_SIDE(1)) u_ml (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(v_m2),
        .i_a(coef_mag(r_coef_l)), .i_b(s_m2[32:1]), .i_side(1'b0),
        .o_valid(), .o_prod(p_l), .o_side()
    );

    logic [ACC_W-1:0] e_c, e_s, e_l;
    logic [ACC_W-1:0] n_t5, n_tc, n_ts, n_tl;
    logic [ACC_W-1:0] r_t5, r_tc, r_ts, r_tl, r_sa, r_sb, r_acc, r_mag;
    logic             r_v7, r_v8, r_v9, r_v10;
    logic             r_b7, r_b8, r_b9, r_b10;
    logic             r_neg10, r_zero10;

    always_comb begin
        e_c  = ACC_W'(p_c);
        e_s  = ACC_W'(p_s);
        e_l  = ACC_W'(p_l);
        n_t5 = ACC_W'({p_m3[75:28], 32'b0});
        n_tc = '0;
        n_ts = '0;
        n_tl = '0;
        if (r_pn_order >= PN_2PN) begin
            n_tc = r_coef_c[COEF_W-1] ? (~e_c + 1'b1) : e_c;
        end
        if (r_pn_order >= PN_3PN) begin
            n_ts = r_coef_s[COEF_W-1] ? e_s : (~e_s + 1'b1);
        end
        if (r_pn_order >= PN_4PN) begin
            n_tl = r_coef_l[COEF_W-1] ? (~e_l + 1'b1) : e_l;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7  <= 1'b0;
            r_v8  <= 1'b0;
            r_v9  <= 1'b0;
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v7  <= v_m3;
            r_v8  <= r_v7;
            r_v9  <= r_v8;
            r_v10 <= r_v9;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t5     <= n_t5;
            r_tc     <= n_tc;
            r_ts     <= n_ts;
            r_tl     <= n_tl;
            r_b7     <= b_m3;
            r_sa     <= r_t5 + r_tc;
            r_sb     <= r_ts + r_tl;
            r_b8     <= r_b7;
            r_acc    <= r_sa + r_sb;
            r_b9     <= r_b8;
            r_neg10  <= r_acc[ACC_W-1];
            r_mag    <= r_acc[ACC_W-1] ? (~r_acc + 1'b1) : r_acc;
            r_zero10 <= (r_acc == '0);
            r_b10    <= r_b9;
        end
    end

    logic             v_dq;
    logic [ACC_W-1:0] dq;
    t_div_side        s_dq;

    ipn_div #(.WN(ACC_W), .WD(DIV_W), .W_SIDE(3)) u_div (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(r_v10),
        .i_num(r_mag), .i_den({r_eta, 4'b0}),
        .i_side({r_neg10, r_zero10, r_b10}),
        .o_valid(v_dq), .o_quot(dq), .o_side(s_dq)
    );

    logic [PHASE_W-1:0] n_phase, r_phase;
    logic               r_bad;

    always_comb begin
        if (s_dq.bad || s_dq.zero) begin
            n_phase = '0;
        end else if (r_eta == '0) begin
            n_phase = s_dq.s_neg ? PHASE_MAX : PHASE_MIN;
        end else if (s_dq.s_neg) begin
            n_phase = (dq[ACC_W-1:PHASE_W-1] != '0) ? PHASE_MAX : dq[PHASE_W-1:0];
        end else begin
            n_phase = ((dq[ACC_W-1:PHASE_W] != '0) ||
                       (dq[PHASE_W-1] && (dq[PHASE_W-2:0] != '0)))
                      ? PHASE_MIN : (~dq[PHASE_W-1:0] + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= v_dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_phase <= n_phase;
            r_bad   <= s_dq.bad;
        end
    end

    assign o_out_valid = r_ov;
    assign o_phase     = r_phase;
    assign o_bad_time  = r_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_time |-> o_phase == '0)
        else $error("bad time with nonzero phase");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v0 |-> o_in_ready)
        else $error("empty input stage not ready");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_mag) && $stable(r_acc))
        else $error("sum stages moved during stall");
endmodule
`default_nettype wire

/* hdl/ipn_isqrt.sv */
// Pipelined floor square root, one result bit per register stage.
// Depends on ipn_pkg.
`default_nettype none
module ipn_isqrt
    import ipn_pkg::*;
#(
    parameter int W_SIDE = 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [RAD_W-1:0]     i_rad,
    input  wire [W_SIDE-1:0]    i_side,
    output logic                o_valid,
    output logic [ROOT_W-1:0]   o_root,
    output logic [W_SIDE-1:0]   o_side
);
    localparam int STAGES = RAD_W / 2;

    logic [RAD_W-1:0]  w_x    [STAGES+1];
    logic [RAD_W-1:0]  w_res  [STAGES+1];
    logic              w_v    [STAGES+1];
    logic [W_SIDE-1:0] w_side [STAGES+1];

    assign w_x[0]    = i_rad;
    assign w_res[0]  = '0;
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
        logic [RAD_W-1:0]  r_x, r_res, n_x, n_res, w_sum;
        logic              r_v;
        logic [W_SIDE-1:0] r_side;

        always_comb begin
            w_sum = w_res[k] + BIT;
            if (w_x[k] >= w_sum) begin
                n_x   = w_x[k] - w_sum;
                n_res = (w_res[k] >> 1) + BIT;
            end else begin
                n_x   = w_x[k];
                n_res = w_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= n_x;
                r_res  <= n_res;
                r_side <= w_side[k];
            end
        end

        assign w_x[k+1]    = r_x;
        assign w_res[k+1]  = r_res;
        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[STAGES];
    assign o_root  = w_res[STAGES][ROOT_W-1:0];
    assign o_side  = w_side[STAGES];
endmodule
`default_nettype wire

/* hdl/ipn_mul.sv */
// Two-stage unsigned multiplier: split partial products, then a shifted add.
// Depends on ipn_pkg.
`default_nettype none
module ipn_mul
    import ipn_pkg::*;
#(
    parameter int WA     = 32,
    parameter int WB     = 32,
    parameter int W_SIDE = 1
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [WA-1:0]        i_a,
    input  wire [WB-1:0]        i_b,
    input  wire [W_SIDE-1:0]    i_side,
    output logic                o_valid,
    output logic [WA+WB-1:0]    o_prod,
    output logic [W_SIDE-1:0]   o_side
);
    localparam int WL = WA / 2;
    localparam int WH = WA - WL;

    logic [WL+WB-1:0]  r_pl;
    logic [WH+WB-1:0]  r_ph;
    logic              r_v1, r_v2;
    logic [W_SIDE-1:0] r_side1, r_side2;
    logic [WA+WB-1:0]  r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl    <= i_a[WL-1:0] * i_b;
            r_ph    <= i_a[WA-1:WL] * i_b;
            r_side1 <= i_side;
            r_prod  <= (WA+WB)'(r_pl) + ((WA+WB)'(r_ph) << WL);
            r_side2 <= r_side1;
        end
    end

    assign o_valid = r_v2;
    assign o_prod  = r_prod;
    assign o_side  = r_side2;
endmodule
`default_nettype wire

/* hdl/ipn_div.sv */
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on ipn_pkg.
`default_nettype none
module ipn_div
    import ipn_pkg::*;
#(
    parameter int WN     = 90,
    parameter int WD     = 36,
    parameter int W_SIDE = 3
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire [WN-1:0]        i_num,
    input  wire [WD-1:0]        i_den,
    input  wire [W_SIDE-1:0]    i_side,
    output logic                o_valid,
    output logic [WN-1:0]       o_quot,
    output logic [W_SIDE-1:0]   o_side
);
    logic [WN-1:0]     w_nq   [WN+1];
    logic [WD-1:0]     w_rem  [WN+1];
    logic              w_v    [WN+1];
    logic [W_SIDE-1:0] w_side [WN+1];

    assign w_nq[0]   = i_num;
    assign w_rem[0]  = '0;
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;

    for (genvar k = 0; k < WN; k++) begin : g_stage
        logic [WD:0]       w_rn;
        logic              w_ge;
        logic [WD-1:0]     r_rem, n_rem;
        logic [WN-1:0]     r_nq;
        logic              r_v;
        logic [W_SIDE-1:0] r_side;

        always_comb begin
            w_rn  = {w_rem[k], w_nq[k][WN-1]};
            w_ge  = (w_rn >= {1'b0, i_den});
            n_rem = w_ge ? WD'(w_rn - {1'b0, i_den}) : WD'(w_rn);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= n_rem;
                r_nq   <= {w_nq[k][WN-2:0], w_ge};
                r_side <= w_side[k];
            end
        end

        assign w_nq[k+1]   = r_nq;
        assign w_rem[k+1]  = r_rem;
        assign w_v[k+1]    = r_v;
        assign w_side[k+1] = r_side;
    end

    assign o_valid = w_v[WN];
    assign o_quot  = w_nq[WN];
    assign o_side  = w_side[WN];
endmodule
`default_nettype wire
